// ----- design/lcdsb_pkg.sv -----
package lcdsb_pkg;

   // Store geometry
   localparam int MAX_COLUMNS = 16;
   localparam int LINE_COUNT  = 2;
   localparam int NUM_ENTRIES = LINE_COUNT * MAX_COLUMNS;
   localparam int ADDR_W      = $clog2(NUM_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
   localparam int STEP_W      = 4;
   localparam int INIT_STEPS  = 9;

   // Operation codes carried in the request kind
   typedef enum logic [2:0] {
      MODE_INIT        = 3'd0,
      MODE_WRITE       = 3'd1,
      MODE_CLEAR       = 3'd2,
      MODE_REFRESH     = 3'd3,
      MODE_CLEAR_ALL   = 3'd4,
      MODE_CLEAR_SHOW  = 3'd5
   } mode_type;

   // Line select codes
   localparam logic [1:0] SEL_NONE = 2'd0;
   localparam logic [1:0] SEL_ONE  = 2'd1;
   localparam logic [1:0] SEL_TWO  = 2'd2;
   localparam logic [1:0] SEL_BOTH = 2'd3;

   // Configuration register indexes
   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_SUPPLY  = 1'b1;

   // Panel bytes
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_LINE_ONE = 8'h80;
   localparam logic [7:0] CMD_LINE_TWO = 8'hC0;
   localparam logic [7:0] WAIT_CLEAR   = 8'd20;

   // Setup command for one step of the init sequence
   function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] step, input logic is_5v);
      logic [7:0] v;
      case (step)
         4'd0:    v = 8'h38;
         4'd1:    v = 8'h39;
         4'd2:    v = 8'h14;
         4'd3:    v = is_5v ? 8'h7A : 8'h73;
         4'd4:    v = is_5v ? 8'h50 : 8'h56;
         4'd5:    v = 8'h6C;
         4'd6:    v = 8'h38;
         4'd7:    v = 8'h01;
         4'd8:    v = 8'h0C;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // Wait in ms after each init step
   function automatic logic [7:0] init_wait(input logic [STEP_W-1:0] step);
      logic [7:0] w;
      case (step)
         4'd5:    w = 8'd200;
         4'd7:    w = 8'd20;
         default: w = 8'd2;
      endcase
      return w;
   endfunction

endpackage

// ----- design/char_lcd_shadow_buffer_refresh_unit.sv -----
// Character LCD shadow store and refresh sequencer.
// Requests arrive on req_* (tuser = operation, tdata = line, column,
// character, line select). Each request yields zero or more panel bytes on
// rsp_* (tuser = data flag, tdata = byte and wait time, tlast on the final
// byte of the request). csr_* writes the column count and supply setting.
// Write and clear requests emit nothing. Init emits nine
// command bytes, clear-all one, refresh a cursor byte plus one byte per
// column in use per line; clear-and-refresh up to 35 bytes.
// Bytes leave one per cycle while rsp_tready is high: the sequencer issues a
// store read, the store returns it in the next cycle into a pending stage,
// then the output register. The first byte passes both stages before it is
// presented. The sequencer stays busy while it issues a request's bytes; the
// next request is taken on the cycle after the last byte has been issued,
// while earlier bytes may still wait.
// Reset empties the pipeline and marks every store entry unwritten, so it
// reads as a space; no clearing pass is needed. Columns reset to 16, supply
// to 3.3 V. When rsp_tready is low a held output byte stays, the pending
// stage holds behind it, the sequencer pauses; nothing is lost or repeated.
module char_lcd_shadow_buffer_refresh_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // line[0], column[8:1], character[16:9], line_select[18:17]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // value[7:0], wait_ms[15:8]
   output logic        rsp_tuser,   // is_data
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int AW = lcdsb_pkg::ADDR_W;
   localparam int CW = lcdsb_pkg::CNT_W;
   localparam int SW = lcdsb_pkg::STEP_W;
   localparam int NE = lcdsb_pkg::NUM_ENTRIES;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CLR,
      ST_CURSOR,
      ST_CHARS
   } state_type;

   // Request fields
   logic       req_line;
   logic [7:0] req_column;
   logic [7:0] req_char;
   logic [1:0] req_sel;
   logic       req_fire;

   assign req_line   = req_tdata[0];
   assign req_column = req_tdata[8:1];
   assign req_char   = req_tdata[16:9];
   assign req_sel    = req_tdata[18:17];

   // Configuration registers
   logic [4:0] columns_ff;
   logic       supply_5v_ff;
   logic [CW-1:0] eff_cols;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= 5'(lcdsb_pkg::MAX_COLUMNS);
         supply_5v_ff <= 1'b0;
      end else if (csr_wr_en) begin
         if (csr_index == lcdsb_pkg::CSR_COLUMNS) begin
            columns_ff <= csr_wdata;
         end else begin
            supply_5v_ff <= csr_wdata[0];
         end
      end
   end

   // Column count clamped to the store width
   assign eff_cols = (32'(columns_ff) > lcdsb_pkg::MAX_COLUMNS) ?
                     CW'(lcdsb_pkg::MAX_COLUMNS) : CW'(columns_ff);

   // Sequencer state
   state_type     state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic          line_ff, line_in;
   logic          both_ff, both_in;
   logic          then_ff, then_in;
   logic [CW-1:0] col_ff, col_in;
   logic [NE-1:0] valid_ff, valid_in;

   // Pending stage (byte whose store read is in flight)
   logic       pend_valid_ff, pend_valid_in;
   logic       pend_data_ff;
   logic       pend_mem_ff;
   logic       pend_blank_ff;
   logic [7:0] pend_value_ff;
   logic [7:0] pend_wait_ff;
   logic       pend_last_ff;

   // Output register
   logic       out_valid_ff, out_valid_in;
   logic       out_data_ff;
   logic [7:0] out_value_ff;
   logic [7:0] out_wait_ff;
   logic       out_last_ff;

   // Byte produced by the sequencer this cycle
   logic          gen_data;
   logic          gen_mem;
   logic          gen_blank;
   logic [7:0]    gen_value;
   logic [7:0]    gen_wait;
   logic          gen_last;
   logic          more_lines;
   logic          advance;
   logic          move_out;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign move_out = pend_valid_ff && (!out_valid_ff || rsp_tready);
   assign advance  = (state_ff != ST_IDLE) && (!pend_valid_ff || move_out);

   assign more_lines = both_ff && !line_ff;
   assign rd_addr = AW'(AW'(line_ff) * AW'(lcdsb_pkg::MAX_COLUMNS)) + AW'(col_ff);

   // Store write for a character request
   assign wr_en   = req_fire && (req_tuser == lcdsb_pkg::MODE_WRITE) &&
                    (32'(req_line) < lcdsb_pkg::LINE_COUNT) &&
                    (req_column < 8'(eff_cols));
   assign wr_addr = AW'(AW'(req_line) * AW'(lcdsb_pkg::MAX_COLUMNS)) +
                    AW'(req_column[CW-2:0]);

   lcdsb_ram #(
      .WIDTH (8),
      .DEPTH (NE)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_char),
      .rd_en   (advance && (state_ff == ST_CHARS)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Byte generation and sequencer next state
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      line_in   = line_ff;
      both_in   = both_ff;
      then_in   = then_ff;
      col_in    = col_ff;
      gen_data  = 1'b0;
      gen_mem   = 1'b0;
      gen_blank = 1'b0;
      gen_value = 8'h00;
      gen_wait  = 8'h00;
      gen_last  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               line_in = 1'b0;
               both_in = 1'b0;
               col_in  = '0;
               step_in = '0;
               case (req_tuser)
                  lcdsb_pkg::MODE_INIT: begin
                     state_in = ST_INIT;
                  end
                  lcdsb_pkg::MODE_REFRESH: begin
                     if (req_sel == lcdsb_pkg::SEL_ONE) begin
                        state_in = ST_CURSOR;
                     end else if (req_sel == lcdsb_pkg::SEL_TWO) begin
                        if (lcdsb_pkg::LINE_COUNT > 1) begin
                           state_in = ST_CURSOR;
                           line_in  = 1'b1;
                        end
                     end else if (req_sel == lcdsb_pkg::SEL_BOTH) begin
                        state_in = ST_CURSOR;
                        both_in  = (lcdsb_pkg::LINE_COUNT > 1);
                     end
                  end
                  lcdsb_pkg::MODE_CLEAR_ALL: begin
                     state_in = ST_CLR;
                     then_in  = 1'b0;
                  end
                  lcdsb_pkg::MODE_CLEAR_SHOW: begin
                     state_in = ST_CLR;
                     then_in  = 1'b1;
                     both_in  = (lcdsb_pkg::LINE_COUNT > 1);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            gen_value = lcdsb_pkg::init_cmd(step_ff, supply_5v_ff);
            gen_wait  = lcdsb_pkg::init_wait(step_ff);
            gen_last  = (32'(step_ff) == lcdsb_pkg::INIT_STEPS - 1);
            if (advance) begin
               step_in = step_ff + SW'(1);
               if (gen_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CLR: begin
            gen_value = lcdsb_pkg::CMD_CLEAR;
            gen_wait  = lcdsb_pkg::WAIT_CLEAR;
            gen_last  = !then_ff;
            if (advance) begin
               state_in = then_ff ? ST_CURSOR : ST_IDLE;
            end
         end
         ST_CURSOR: begin
            gen_value = line_ff ? lcdsb_pkg::CMD_LINE_TWO : lcdsb_pkg::CMD_LINE_ONE;
            gen_last  = (eff_cols == '0) && !more_lines;
            if (advance) begin
               col_in = '0;
               if (eff_cols != '0) begin
                  state_in = ST_CHARS;
               end else if (more_lines) begin
                  line_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CHARS: begin
            gen_data  = 1'b1;
            gen_mem   = 1'b1;
            gen_blank = !valid_ff[rd_addr];
            gen_last  = ((col_ff + CW'(1)) == eff_cols) && !more_lines;
            if (advance) begin
               col_in = col_ff + CW'(1);
               if ((col_ff + CW'(1)) == eff_cols) begin
                  if (more_lines) begin
                     state_in = ST_CURSOR;
                     line_in  = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Written marks: an unmarked entry reads as a space
   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         case (req_tuser)
            lcdsb_pkg::MODE_INIT,
            lcdsb_pkg::MODE_CLEAR_ALL: begin
               valid_in = '0;
            end
            lcdsb_pkg::MODE_CLEAR: begin
               if (req_sel == lcdsb_pkg::SEL_BOTH) begin
                  valid_in = '0;
               end else if (req_sel != lcdsb_pkg::SEL_NONE) begin
                  for (int ln = 0; ln < lcdsb_pkg::LINE_COUNT; ln++) begin
                     for (int c = 0; c < lcdsb_pkg::MAX_COLUMNS; c++) begin
                        if ((ln == int'(req_sel) - 1) && (CW'(c) < eff_cols)) begin
                           valid_in[ln * lcdsb_pkg::MAX_COLUMNS + c] = 1'b0;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // Stage handshakes
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (advance) begin
         pend_valid_in = 1'b1;
      end else if (move_out) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         line_ff       <= 1'b0;
         both_ff       <= 1'b0;
         then_ff       <= 1'b0;
         col_ff        <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         line_ff       <= line_in;
         both_ff       <= both_in;
         then_ff       <= then_in;
         col_ff        <= col_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload of pending and output stages
   always_ff @(posedge clock) begin
      if (advance) begin
         pend_data_ff  <= gen_data;
         pend_mem_ff   <= gen_mem;
         pend_blank_ff <= gen_blank;
         pend_value_ff <= gen_value;
         pend_wait_ff  <= gen_wait;
         pend_last_ff  <= gen_last;
      end
      if (move_out) begin
         out_data_ff  <= pend_data_ff;
         out_value_ff <= !pend_mem_ff   ? pend_value_ff :
                         pend_blank_ff  ? lcdsb_pkg::BLANK_CHAR : rd_data;
         out_wait_ff  <= pend_wait_ff;
         out_last_ff  <= pend_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_wait_ff, out_value_ff};
   assign rsp_tuser  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- design/lcdsb_ram.sv -----
module lcdsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read that holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
